/* rtl/core/idf_pkg.sv */
// Shared constants, types and helpers of the IMU packet deframer.
`default_nettype none

package idf_pkg;

  // Bytes collected after the start byte.
  localparam int unsigned PACKET_LEN = 30;

  localparam logic [7:0] LEAD_BYTE  = 8'hFA;
  localparam logic [7:0] START_BYTE = 8'hFF;
  // Running sum that makes (sum + START_BYTE) wrap to zero.
  localparam logic [7:0] SUM_GOOD   = 8'h01;

  localparam int unsigned ACCEL_OFS = 5;
  localparam int unsigned RATE_OFS  = 17;
  localparam int unsigned NUM_WORDS = 6;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned TALLY_W   = 8;
  localparam int unsigned POS_W     = $clog2(PACKET_LEN);

  // The chain only has to reach back to the first accelerometer byte.
  localparam int unsigned NUM_CELLS = PACKET_LEN - 1 - ACCEL_OFS;

  localparam int unsigned OUT_DATA_W = NUM_WORDS * WORD_W + TALLY_W;

  typedef struct packed {
    logic               shift_en;   // a packet byte is accepted this cycle
    logic               done;       // the last packet byte is accepted
    logic               last_pos;   // the next packet byte is the last one
    logic               sum_ok;     // checksum of the finishing packet
    logic [TALLY_W-1:0] bad_count;  // error tally including this packet
  } idf_ctrl_t;

  // Packet offset of the first byte of result word j.
  function automatic int unsigned word_ofs(input int unsigned j);
    int unsigned ofs;
    if (j < 3) begin
      ofs = ACCEL_OFS + 4 * j;
    end else begin
      ofs = RATE_OFS + 4 * (j - 3);
    end
    return ofs;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/imu_packet_deframer.sv */
// IMU packet deframer: a byte stream in, one checked sensor record per packet out.
//
// Usage:
//   The slave channel takes one received byte per request in s_axis_tdata.
//   While hunting, a 0xFA byte followed by 0xFF starts a packet; the next
//   PACKET_LEN bytes are shifted through a chain of byte cells and summed.
//   On the last packet byte one result request is produced on the master
//   channel: tuser bit 0 is the checksum flag, tdata carries six big-endian
//   32-bit words (acceleration x/y/z, rates roll/pitch/yaw) and the 8-bit
//   wrapping count of bad packets. A bad packet reports all six words as 0.
//   Throughput: one byte per cycle, limited by the single-cycle byte chain
//   and running sum. Latency: the result is valid in the cycle after the
//   last packet byte is accepted, held in an output register.
//   When the receiver stalls, bytes keep flowing in; only the last byte of a
//   following packet waits while the previous result is still unread.
//   Reset (rst_ni low, asynchronous) returns to hunting, clears the lead
//   memory, the checksum, the error count and the output valid flag.
`default_nettype none

module imu_packet_deframer (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // From bit 0: accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw,
  // bad_count.
  output logic      [idf_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  output logic      [0:0]                        m_axis_tuser    // [0] sum_ok
);

  localparam int unsigned WORDS_W = idf_pkg::NUM_WORDS * idf_pkg::WORD_W;

  idf_pkg::idf_ctrl_t              ctrl;
  logic                            s_accept;
  logic                            m_accept;
  logic [7:0]                      chain [idf_pkg::NUM_CELLS];
  logic [WORDS_W-1:0]              words;
  logic                            valid_q, valid_d;
  logic [idf_pkg::OUT_DATA_W-1:0]  data_q, data_d;
  logic                            ok_q, ok_d;

  // Only the last byte of a packet needs a free output register.
  assign s_axis_tready = !ctrl.last_pos || !valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign m_accept      = valid_q && m_axis_tready;

  idf_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (s_accept),
    .byte_i   (s_axis_tdata),
    .ctrl_o   (ctrl)
  );

  // Cell 0 holds the newest packet byte; older bytes move one cell further.
  for (genvar i = 0; i < idf_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_head
      idf_cell u_cell (
        .clk_i (clk_i),
        .en_i  (ctrl.shift_en),
        .d_i   (s_axis_tdata),
        .q_o   (chain[i])
      );
    end else begin : g_body
      idf_cell u_cell (
        .clk_i (clk_i),
        .en_i  (ctrl.shift_en),
        .d_i   (chain[i-1]),
        .q_o   (chain[i])
      );
    end
  end

  // At the last byte, packet byte k sits in cell PACKET_LEN-2-k, and the
  // final packet byte is the one on the input bus.
  for (genvar j = 0; j < idf_pkg::NUM_WORDS; j++) begin : g_word
    for (genvar b = 0; b < 4; b++) begin : g_byte
      localparam int unsigned IDX = idf_pkg::word_ofs(j) + b;
      localparam int unsigned LSB = j * idf_pkg::WORD_W + (3 - b) * 8;
      if (IDX == idf_pkg::PACKET_LEN - 1) begin : g_live
        assign words[LSB +: 8] = s_axis_tdata;
      end else begin : g_held
        assign words[LSB +: 8] = chain[idf_pkg::PACKET_LEN - 2 - IDX];
      end
    end
  end

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    ok_d    = ok_q;
    if (m_accept) begin
      valid_d = 1'b0;
    end
    if (ctrl.done) begin
      valid_d = 1'b1;
      ok_d    = ctrl.sum_ok;
      data_d  = {ctrl.bad_count, ctrl.sum_ok ? words : {WORDS_W{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    ok_q   <= ok_d;
  end

  assign m_axis_tvalid   = valid_q;
  assign m_axis_tdata    = data_q;
  assign m_axis_tuser[0] = ok_q;

  a_bad_words_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !ok_q) |-> (data_q[WORDS_W-1:0] == '0))
    else $error("bad packet reports nonzero sensor words");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready) |-> !ctrl.done)
    else $error("result register overwritten while unread");

  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !m_axis_tready) |=> (valid_q && $stable(data_q) && $stable(ok_q)))
    else $error("result request changed while stalled");

endmodule

`default_nettype wire

/* rtl/core/idf_cell.sv */
// One byte cell of the packet shift chain.
`default_nettype none

module idf_cell (
  input  wire logic       clk_i,
  input  wire logic       en_i,
  input  wire logic [7:0] d_i,
  output logic      [7:0] q_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = en_i ? d_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign q_o = byte_q;

endmodule

`default_nettype wire

/* rtl/core/idf_ctrl.sv */
// Frame hunting, byte position, checksum and error tally of the deframer.
`default_nettype none

module idf_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               accept_i,
  input  wire logic [7:0]         byte_i,
  output idf_pkg::idf_ctrl_t      ctrl_o
);

  typedef enum logic [1:0] {
    ST_HUNT    = 2'b01,
    ST_COLLECT = 2'b10
  } idf_state_e;

  localparam logic [idf_pkg::POS_W-1:0] LAST_POS =
    idf_pkg::POS_W'(idf_pkg::PACKET_LEN - 1);

  idf_state_e                        state_q, state_d;
  logic                              lead_q, lead_d;
  logic [idf_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [7:0]                        sum_q, sum_d;
  logic [idf_pkg::TALLY_W-1:0]       tally_q, tally_d;
  logic [7:0]                        sum_next;
  logic                              shift_en;
  logic                              done;

  assign sum_next = sum_q + byte_i;

  always_comb begin
    state_d  = state_q;
    lead_d   = lead_q;
    pos_d    = pos_q;
    sum_d    = sum_q;
    tally_d  = tally_q;
    shift_en = 1'b0;
    done     = 1'b0;
    unique case (state_q)
      ST_HUNT: begin
        if (accept_i) begin
          // The lead memory stays set when a packet starts.
          if (byte_i == idf_pkg::LEAD_BYTE) begin
            lead_d = 1'b1;
          end else if (byte_i == idf_pkg::START_BYTE) begin
            if (lead_q) begin
              state_d = ST_COLLECT;
              pos_d   = '0;
              sum_d   = '0;
            end
          end else begin
            lead_d = 1'b0;
          end
        end
      end
      ST_COLLECT: begin
        if (accept_i) begin
          shift_en = 1'b1;
          sum_d    = sum_next;
          if (pos_q == LAST_POS) begin
            done    = 1'b1;
            state_d = ST_HUNT;
            pos_d   = '0;
            if (sum_next != idf_pkg::SUM_GOOD) begin
              tally_d = tally_q + 1'b1;
            end
          end else begin
            pos_d = pos_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
      lead_q  <= 1'b0;
      pos_q   <= '0;
      sum_q   <= '0;
      tally_q <= '0;
    end else begin
      state_q <= state_d;
      lead_q  <= lead_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      tally_q <= tally_d;
    end
  end

  assign ctrl_o.shift_en  = shift_en;
  assign ctrl_o.done      = done;
  assign ctrl_o.last_pos  = (state_q == ST_COLLECT) && (pos_q == LAST_POS);
  assign ctrl_o.sum_ok    = (sum_next == idf_pkg::SUM_GOOD);
  assign ctrl_o.bad_count = tally_d;

  // A packet can only have started from a set lead memory, which it keeps.
  a_collect_has_lead: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COLLECT) |-> lead_q)
    else $error("collecting without lead memory");

  a_pos_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HUNT) |-> (pos_q == '0))
    else $error("byte position nonzero while hunting");

  a_done_returns_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> (state_q == ST_HUNT))
    else $error("still collecting after the last packet byte");

  a_tally_steps_on_bad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tally_q != $past(tally_q)) |-> ($past(done) && !$past(ctrl_o.sum_ok)))
    else $error("error tally moved without a bad packet");

endmodule

`default_nettype wire

/* bench/idf_stream_checker.sv */
// Checker for the IMU packet deframer: predicts every sensor record and compares the output.
`timescale 1ns / 1ps

module idf_stream_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  input  wire logic                           s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] rx_byte
  input  wire logic                           m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // From bit 0: accel_x, accel_y, accel_z, rate_roll, rate_pitch, rate_yaw,
  // bad_count.
  input  wire logic [idf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  wire logic [0:0]                     m_axis_tuser,   // [0] sum_ok
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  localparam int unsigned PLEN    = idf_pkg::PACKET_LEN;
  localparam int unsigned NWORDS  = idf_pkg::NUM_WORDS;
  localparam int unsigned WORD_W  = idf_pkg::WORD_W;
  localparam int unsigned TALLY_W = idf_pkg::TALLY_W;

  typedef struct packed {
    logic                           sum_ok;
    logic [TALLY_W-1:0]             bad_count;
    logic [NWORDS-1:0][WORD_W-1:0]  words;      // words[0] is accel_x
  } imu_record_t;

  string word_names [NWORDS] = '{"accel_x", "accel_y", "accel_z",
                                 "rate_roll", "rate_pitch", "rate_yaw"};

  logic               in_frame;
  logic               lead_held;
  logic [7:0]         frame_pos;
  logic [7:0]         frame_bytes [PLEN];
  logic [7:0]         frame_sum;
  logic [TALLY_W-1:0] bad_tally;
  imu_record_t        due_records [$];
  int unsigned        fails;

  // Advances the deframer state by one accepted byte and queues the record
  // that the last byte of a packet produces.
  task automatic absorb_byte(input logic [7:0] b);
    imu_record_t rec;
    int unsigned ofs;
    if (!in_frame) begin
      if (b == idf_pkg::LEAD_BYTE) begin
        lead_held = 1'b1;
      end else if (b == idf_pkg::START_BYTE) begin
        // The lead memory is kept, so a later start byte alone opens a packet.
        if (lead_held) begin
          in_frame  = 1'b1;
          frame_pos = '0;
          frame_sum = '0;
        end
      end else begin
        lead_held = 1'b0;
      end
    end else begin
      frame_bytes[frame_pos] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 8'd1;
      if (frame_pos == PLEN) begin
        in_frame  = 1'b0;
        frame_pos = '0;
        rec = '0;
        if (frame_sum != idf_pkg::SUM_GOOD) begin
          bad_tally = bad_tally + 1'b1;
        end else begin
          rec.sum_ok = 1'b1;
          for (int w = 0; w < NWORDS; w++) begin
            ofs = (w < 3) ? idf_pkg::ACCEL_OFS + 4 * w : idf_pkg::RATE_OFS + 4 * (w - 3);
            rec.words[w] = {frame_bytes[ofs], frame_bytes[ofs + 1],
                            frame_bytes[ofs + 2], frame_bytes[ofs + 3]};
          end
        end
        rec.bad_count = bad_tally;
        due_records.push_back(rec);
      end
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, want_v, got_v);
    fails++;
  endtask

  task automatic check_record();
    imu_record_t got;
    imu_record_t want;
    got.sum_ok    = m_axis_tuser[0];
    got.words     = m_axis_tdata[NWORDS*WORD_W-1:0];
    got.bad_count = m_axis_tdata[idf_pkg::OUT_DATA_W-1 -: TALLY_W];
    if (due_records.size() == 0) begin
      $display("%0t ns: unexpected record: expected none, actual sum_ok %0d data %h",
               $time, got.sum_ok, m_axis_tdata);
      fails++;
    end else begin
      want = due_records.pop_front();
      if (want.sum_ok != got.sum_ok) begin
        note_mismatch("sum_ok", 32'(want.sum_ok), 32'(got.sum_ok));
      end
      for (int w = 0; w < NWORDS; w++) begin
        if (want.words[w] != got.words[w]) begin
          note_mismatch(word_names[w], want.words[w], got.words[w]);
        end
      end
      if (want.bad_count != got.bad_count) begin
        note_mismatch("bad_count", 32'(want.bad_count), 32'(got.bad_count));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame  = 1'b0;
      lead_held = 1'b0;
      frame_pos = '0;
      frame_sum = '0;
      bad_tally = '0;
      due_records.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // A record never leaves in the cycle of its last byte, so the
      // output is checked before this cycle's byte is absorbed.
      if (m_axis_tvalid && m_axis_tready) begin
        check_record();
      end
      if (s_axis_tvalid && s_axis_tready) begin
        absorb_byte(s_axis_tdata);
      end
      fail_count_o <= fails;
      pending_o    <= due_records.size();
    end
  end

endmodule

/* bench/tb_imu_packet_deframer.sv */
// Testbench top for the IMU packet deframer: byte stimulus, output stalls and verdict.
`timescale 1ns / 1ps

module tb_imu_packet_deframer;

  localparam int unsigned PLEN         = idf_pkg::PACKET_LEN;
  localparam int unsigned RANDOM_BYTES = 850;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_MARKERS} fill_e;
  typedef enum int {LEAD_NONE, LEAD_START_ONLY, LEAD_FULL} lead_e;

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = 8'h00;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [idf_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned bytes_sent = 0;
  bit          calm = 1'b0;

  imu_packet_deframer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  idf_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 11);
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the byte request is
  // accepted. Ready is sampled at the falling edge, where it is settled.
  task automatic push_byte(input logic [7:0] b);
    if (!calm && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic push_packet(input lead_e lead, input bit good, input fill_e fill);
    logic [7:0] body [PLEN];
    logic [7:0] sum;
    sum = '0;
    for (int k = 0; k < PLEN - 1; k++) begin
      case (fill)
        FILL_ZERO:    body[k] = 8'h00;
        FILL_ONES:    body[k] = 8'hFF;
        FILL_MARKERS: body[k] = $urandom_range(1) ? idf_pkg::LEAD_BYTE : idf_pkg::START_BYTE;
        default:      body[k] = 8'($urandom_range(255));
      endcase
      sum = sum + body[k];
    end
    // The last byte settles the checksum either way.
    if (good) begin
      body[PLEN-1] = idf_pkg::SUM_GOOD - sum;
    end else begin
      body[PLEN-1] = 8'($urandom_range(255));
      if (8'(sum + body[PLEN-1]) == idf_pkg::SUM_GOOD) begin
        body[PLEN-1] = body[PLEN-1] + 8'd1;
      end
    end
    if (lead == LEAD_FULL) begin
      push_byte(idf_pkg::LEAD_BYTE);
    end
    if (lead != LEAD_NONE) begin
      push_byte(idf_pkg::START_BYTE);
    end
    for (int k = 0; k < PLEN; k++) begin
      push_byte(body[k]);
    end
  endtask

  task automatic push_noise_byte();
    push_byte(8'($urandom_range(255)));
  endtask

  initial begin : stimulus
    int unsigned pick;
    int unsigned random_start;
    lead_e       lead;
    fill_e       fill;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Hunting: a start byte with no lead, a lead cleared by another byte.
    push_byte(8'h00);
    push_byte(idf_pkg::START_BYTE);
    push_byte(idf_pkg::LEAD_BYTE);
    push_byte(8'h12);
    push_byte(idf_pkg::START_BYTE);
    // Repeated lead bytes, then packets of all-zero and all-ones data.
    push_byte(idf_pkg::LEAD_BYTE);
    push_packet(LEAD_FULL, 1'b1, FILL_ZERO);
    // The lead memory survives the packet, so a lone start byte opens the next.
    push_packet(LEAD_START_ONLY, 1'b1, FILL_ONES);
    // Marker values inside a packet are plain data; this one fails its checksum.
    push_packet(LEAD_START_ONLY, 1'b0, FILL_MARKERS);
    push_byte(8'h55);
    push_byte(idf_pkg::START_BYTE);
    push_packet(LEAD_FULL, 1'b1, FILL_MARKERS);
    push_packet(LEAD_START_ONLY, 1'b1, FILL_RANDOM);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      calm = (bytes_sent - random_start >= 300) && (bytes_sent - random_start < 600);
      pick = $urandom_range(99);
      if (pick < 65) begin
        case ($urandom_range(9))
          0, 1:    lead = LEAD_START_ONLY;
          2:       lead = LEAD_NONE;
          default: lead = LEAD_FULL;
        endcase
        case ($urandom_range(9))
          0:       fill = FILL_ZERO;
          1:       fill = FILL_ONES;
          2:       fill = FILL_MARKERS;
          default: fill = FILL_RANDOM;
        endcase
        push_packet(lead, $urandom_range(99) < 75, fill);
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 4)) push_noise_byte();
      end else if (pick < 90) begin
        // A lead byte that is not followed by a start byte.
        push_byte(idf_pkg::LEAD_BYTE);
        push_byte(8'($urandom_range(254)));
      end else begin
        // A cut-off packet: the next bytes complete it as data.
        push_byte(idf_pkg::LEAD_BYTE);
        push_byte(idf_pkg::START_BYTE);
        repeat ($urandom_range(1, PLEN - 1)) push_noise_byte();
      end
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* imu_packet_deframer.f */
rtl/core/idf_pkg.sv
rtl/core/idf_cell.sv
rtl/core/idf_ctrl.sv
rtl/core/imu_packet_deframer.sv
bench/idf_stream_checker.sv
bench/tb_imu_packet_deframer.sv
